/* hdl/dcbe_pkg.sv */
// ----------------------------------------------------------------------------
// dcbe_pkg
// Shared types and constants of the Doppler centroid and bandwidth estimator.
// ----------------------------------------------------------------------------
package dcbe_pkg;

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int SL_W       = 11;
	localparam int FS_W       = 17;
	localparam int FRAC_W     = 16;
	localparam int OUT_W      = 25;
	localparam int Q_W        = 25;
	localparam int CFG_DATA_W = 17;
	localparam int MIN_BINS   = 4;

	// Register reset values
	localparam logic [SL_W-1:0]   SL_RESET   = SL_W'(1024);
	localparam logic [FS_W-1:0]   FS_RESET   = FS_W'(5000);
	localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32768);

	// Register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SPECTRUM_LENGTH = 2'd0;
	localparam reg_idx_t REG_AZIMUTH_RATE    = 2'd1;
	localparam reg_idx_t REG_POWER_FRACTION  = 2'd2;

	// Status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NO_ENERGY = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] bin_real;
		logic signed [SAMPLE_W-1:0] bin_imag;
		logic                       image_end;
	} bin_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] centroid_q8;
		logic [OUT_W-1:0]        bandwidth_q8;
		logic                    status;
	} result_word_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_SQ1,
		S_SQ2,
		S_ACC,
		S_SCAN,
		S_THR,
		S_LO_RD,
		S_LO_CMP,
		S_HI_RD,
		S_HI_CMP,
		S_NUM_MUL,
		S_NUM_WAIT,
		S_DEN_MUL,
		S_DEN_WAIT,
		S_CDIV,
		S_CDIV_WAIT,
		S_BW_MUL,
		S_BW_WAIT,
		S_BDIV,
		S_BDIV_WAIT,
		S_RESULT
	} state_t;

endpackage

/* hdl/dcbe_stream_if.sv */
// ----------------------------------------------------------------------------
// dcbe_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface dcbe_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/dcbe_mul.sv */
// ----------------------------------------------------------------------------
// dcbe_mul
// Shift-add multiplier, one bit of the b operand per cycle, MSB first.
// ----------------------------------------------------------------------------
module dcbe_mul #(
	parameter int A_W = 32,
	parameter int B_W = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] product
);
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W+B_W-1:0] acc_q;
	logic [A_W-1:0]     a_q;
	logic [B_W-1:0]     b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (run_q) begin
			acc_q <= (acc_q << 1) + (b_q[B_W-1] ? (A_W+B_W)'(a_q) : '0);
			b_q   <= b_q << 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

/* hdl/dcbe_div.sv */
// ----------------------------------------------------------------------------
// dcbe_div
// Restoring divider, one quotient bit per cycle. Gives Q_W quotient bits plus
// one overflow bit on top.
// ----------------------------------------------------------------------------
module dcbe_div import dcbe_pkg::*; #(
	parameter int N_W = 96,
	parameter int D_W = 70
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [Q_W:0]   quot
);
	localparam int CMP_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;
	localparam int CNT_W = $clog2(Q_W + 2);

	logic [CMP_W-1:0] rem_q;
	logic [CMP_W-1:0] dsh_q;
	logic [Q_W:0]     quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             ge_w;

	assign ge_w = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(Q_W + 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= CMP_W'(num);
			dsh_q  <= CMP_W'(den) << Q_W;
			quot_q <= '0;
		end else if (run_q) begin
			// subtract the shifted divisor where it fits, then move it down a bit
			if (ge_w) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[Q_W-1:0], ge_w};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

/* hdl/doppler_centroid_bandwidth_estimator.sv */
// ----------------------------------------------------------------------------
// doppler_centroid_bandwidth_estimator
// Accumulates azimuth bin power per bin and, at the image end, reports the
// Doppler centroid and the Doppler bandwidth.
// ----------------------------------------------------------------------------
// Each accepted bin passes through these steps: accept and read the power
// store, square the real part, square and add the imaginary part on the
// same multiplier, then write the saturated sum back; ready is low for the
// last three. The last bin of a column with image_end set starts the result
// pass: a scan over the store (sum, first moment, first peak), the threshold
// step, a read and a compare per bin walked down and up from the peak, two
// serial multiplies (start, 17 steps, done) and one divide (start, 26 steps,
// done) for the centroid (skipped when there is no energy), one more multiply
// and divide for the bandwidth, and, while the previous result word is still
// held, a wait for it to be taken before the new one loads. After reset and
// after each result a clearing pass over all MAX_BINS entries zeroes the
// power store; no word is accepted during it, configuration writes are taken
// at any time. The serial multiplier and the divider are the shared units
// that set the length of the result pass.
// ----------------------------------------------------------------------------
module doppler_centroid_bandwidth_estimator import dcbe_pkg::*; #(
	parameter int MAX_BINS    = 1024,
	parameter int ACCUM_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  reg_idx_t              wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	dcbe_stream_if.sink           spectrum,
	dcbe_stream_if.source         estimate
);
	localparam int LEN_W  = $clog2(MAX_BINS + 1);
	localparam int IDX_W  = $clog2(MAX_BINS);
	localparam int DF_W   = LEN_W + 1;
	localparam int PR_W   = ACCUM_WIDTH + 1 + DF_W;
	localparam int MOM_W  = PR_W + IDX_W;
	localparam int DEN_W  = ACCUM_WIDTH + IDX_W;
	localparam int MA_W   = MOM_W;
	localparam int MB_W   = (FS_W > LEN_W) ? FS_W : LEN_W;
	localparam int MP_W   = MA_W + MB_W;
	localparam int NUM_W  = MOM_W + FS_W;
	localparam int DD_W   = DEN_W + LEN_W;
	localparam int SHIFT  = 9;  // times 256 for Q.8, times 2 for rounding
	localparam int DIVN_W = ((NUM_W + SHIFT > DD_W) ? NUM_W + SHIFT : DD_W) + 1;
	localparam int DIVD_W = DD_W + 1;
	localparam int CL_W   = (SL_W > LEN_W) ? SL_W : LEN_W;
	localparam int PW_W   = 2 * SAMPLE_W + 1;
	localparam int THR_W  = ACCUM_WIDTH + FRAC_W;

	localparam logic [Q_W:0]     MAG_CAP = (Q_W + 1)'(1) << (OUT_W - 1);
	localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W - 1){1'b1}}};

	// configuration
	logic [SL_W-1:0]   sl_q;
	logic [FS_W-1:0]   fs_q;
	logic [FRAC_W-1:0] frac_q;

	// control
	state_t           state_q, state_d;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] clr_q;
	logic             res_valid_q;
	logic             v_s1, v_s2;

	// payload
	logic signed [SAMPLE_W-1:0] re_q, im_q;
	logic                       img_q;
	logic [2*SAMPLE_W-1:0]      sq_q;
	logic [PW_W-1:0]            pw_q;
	logic [ACCUM_WIDTH-1:0]     mem_q [MAX_BINS];
	logic [ACCUM_WIDTH-1:0]     rd_data_q;
	logic [LEN_W:0]             k_q;
	logic [IDX_W-1:0]           kd_s1;
	logic signed [PR_W-1:0]     prod_s2;
	logic [DEN_W-1:0]           den_q;
	logic signed [MOM_W-1:0]    mom_q;
	logic [ACCUM_WIDTH-1:0]     peak_val_q;
	logic [IDX_W-1:0]           peak_idx_q;
	logic [THR_W-1:0]           thr_q;
	logic [IDX_W-1:0]           lo_q, hi_q;
	logic [NUM_W-1:0]           num_q;
	logic [OUT_W-1:0]           cen_q;
	logic [OUT_W-1:0]           bw_q;
	logic                       status_q;
	result_word_t               res_q;

	// combinational
	logic [CL_W-1:0]              sl_ext_w;
	logic [LEN_W-1:0]             len_w;
	logic [LEN_W-1:0]             centre_w;
	logic                         last_w;
	logic                         hi_end_w;
	logic                         above_w;
	logic signed [SAMPLE_W-1:0]   sq_in_w;
	logic signed [2*SAMPLE_W-1:0] sq_w;
	logic [ACCUM_WIDTH:0]         acc_sum_w;
	logic [ACCUM_WIDTH-1:0]       acc_sat_w;
	logic signed [DF_W-1:0]       diff_w;
	logic [MOM_W-1:0]             mag_w;
	logic [IDX_W-1:0]             span_w;
	logic [Q_W:0]                 mag_cap_w;
	logic [OUT_W-1:0]             cen_w;
	logic                         in_ready;
	logic                         res_load;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic [IDX_W-1:0]             mem_raddr;
	logic [ACCUM_WIDTH-1:0]       mem_wdata;
	logic                         mul_start, mul_done;
	logic [MA_W-1:0]              mul_a;
	logic [MB_W-1:0]              mul_b;
	logic [MP_W-1:0]              mul_prod;
	logic                         div_start, div_done;
	logic [DIVN_W-1:0]            div_num;
	logic [DIVD_W-1:0]            div_den;
	logic [Q_W:0]                 div_quot;
	state_t                       after_walk_w;

	// Clamp the bin count to [MIN_BINS, MAX_BINS]
	always_comb begin
		sl_ext_w = CL_W'(sl_q);
		if (sl_ext_w < CL_W'(MIN_BINS)) begin
			len_w = LEN_W'(MIN_BINS);
		end else if (sl_ext_w > CL_W'(MAX_BINS)) begin
			len_w = LEN_W'(MAX_BINS);
		end else begin
			len_w = LEN_W'(sl_ext_w);
		end
	end

	assign centre_w = len_w >> 1;
	assign last_w   = ((LEN_W + 1)'(pos_q) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(len_w);
	assign hi_end_w = (LEN_W'(hi_q) + LEN_W'(1)) >= len_w;
	assign above_w  = {rd_data_q, {FRAC_W{1'b0}}} > thr_q;

	// One squarer shared by the real and the imaginary part
	assign sq_in_w = (state_q == S_SQ2) ? im_q : re_q;
	assign sq_w    = sq_in_w * sq_in_w;

	// Saturating add into the power store
	assign acc_sum_w = {1'b0, rd_data_q} + (ACCUM_WIDTH + 1)'(pw_q);
	assign acc_sat_w = acc_sum_w[ACCUM_WIDTH] ? {ACCUM_WIDTH{1'b1}}
	                                          : acc_sum_w[ACCUM_WIDTH-1:0];

	// Bin offset from the spectrum centre
	assign diff_w = $signed(DF_W'(kd_s1) - DF_W'(centre_w));

	assign mag_w  = mom_q[MOM_W-1] ? MOM_W'(-mom_q) : MOM_W'(mom_q);
	assign span_w = hi_q - lo_q;

	// Round-to-nearest magnitude, capped; the positive side stops one short
	always_comb begin
		mag_cap_w = (div_quot > MAG_CAP) ? MAG_CAP : div_quot;
		if (mom_q[MOM_W-1]) begin
			cen_w = -mag_cap_w[OUT_W-1:0];
		end else if (mag_cap_w[OUT_W-1]) begin
			cen_w = POS_MAX;
		end else begin
			cen_w = mag_cap_w[OUT_W-1:0];
		end
	end

	assign after_walk_w = (den_q == '0) ? S_BW_MUL : S_NUM_MUL;

	// Shared unit operands
	always_comb begin
		case (state_q)
			S_NUM_MUL: begin
				mul_a = MA_W'(mag_w);
				mul_b = MB_W'(fs_q);
			end
			S_DEN_MUL: begin
				mul_a = MA_W'(den_q);
				mul_b = MB_W'(len_w);
			end
			default: begin
				mul_a = MA_W'(span_w);
				mul_b = MB_W'(fs_q);
			end
		endcase
	end

	always_comb begin
		if (state_q == S_CDIV) begin
			div_num = (DIVN_W'(num_q) << SHIFT) + DIVN_W'(mul_prod[DD_W-1:0]);
			div_den = DIVD_W'(mul_prod[DD_W-1:0]) << 1;
		end else begin
			div_num = (DIVN_W'(mul_prod[LEN_W+FS_W-1:0]) << SHIFT) + DIVN_W'(len_w);
			div_den = DIVD_W'(len_w) << 1;
		end
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = acc_sat_w;
		mem_raddr = pos_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == IDX_W'(MAX_BINS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (spectrum.valid) begin
					state_d = S_SQ1;
				end
			end
			S_SQ1: state_d = S_SQ2;
			S_SQ2: state_d = S_ACC;
			S_ACC: begin
				mem_we = 1'b1;
				if (last_w && img_q) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				mem_raddr = k_q[IDX_W-1:0];
				if (k_q == (LEN_W + 1)'(len_w) + (LEN_W + 1)'(1)) begin
					state_d = S_THR;
				end
			end
			S_THR: state_d = S_LO_RD;
			S_LO_RD: begin
				mem_raddr = lo_q;
				if (lo_q == '0) begin
					state_d = S_HI_RD;
				end else begin
					state_d = S_LO_CMP;
				end
			end
			S_LO_CMP: begin
				if (above_w) begin
					state_d = S_LO_RD;
				end else begin
					state_d = S_HI_RD;
				end
			end
			S_HI_RD: begin
				mem_raddr = hi_q;
				if (hi_end_w) begin
					state_d = after_walk_w;
				end else begin
					state_d = S_HI_CMP;
				end
			end
			S_HI_CMP: begin
				if (above_w) begin
					state_d = S_HI_RD;
				end else begin
					state_d = after_walk_w;
				end
			end
			S_NUM_MUL: begin
				mul_start = 1'b1;
				state_d   = S_NUM_WAIT;
			end
			S_NUM_WAIT: begin
				if (mul_done) begin
					state_d = S_DEN_MUL;
				end
			end
			S_DEN_MUL: begin
				mul_start = 1'b1;
				state_d   = S_DEN_WAIT;
			end
			S_DEN_WAIT: begin
				if (mul_done) begin
					state_d = S_CDIV;
				end
			end
			S_CDIV: begin
				div_start = 1'b1;
				state_d   = S_CDIV_WAIT;
			end
			S_CDIV_WAIT: begin
				if (div_done) begin
					state_d = S_BW_MUL;
				end
			end
			S_BW_MUL: begin
				mul_start = 1'b1;
				state_d   = S_BW_WAIT;
			end
			S_BW_WAIT: begin
				if (mul_done) begin
					state_d = S_BDIV;
				end
			end
			S_BDIV: begin
				div_start = 1'b1;
				state_d   = S_BDIV_WAIT;
			end
			S_BDIV_WAIT: begin
				if (div_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				// hold until the previous result word has gone
				if (!res_valid_q || estimate.ready) begin
					res_load = 1'b1;
					state_d  = S_CLEAR;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pos_q       <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			sl_q        <= SL_RESET;
			fs_q        <= FS_RESET;
			frac_q      <= FRAC_RESET;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_SCAN) && (k_q < (LEN_W + 1)'(len_w));
			v_s2    <= v_s1;
			if (state_q == S_CLEAR) begin
				clr_q <= (clr_q == IDX_W'(MAX_BINS - 1)) ? '0 : clr_q + 1'b1;
			end
			if (state_q == S_ACC) begin
				pos_q <= last_w ? '0 : pos_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (estimate.ready) begin
				res_valid_q <= 1'b0;
			end
			if (wr_en) begin
				case (wr_index)
					REG_SPECTRUM_LENGTH: sl_q   <= wr_data[SL_W-1:0];
					REG_AZIMUTH_RATE:    fs_q   <= wr_data[FS_W-1:0];
					REG_POWER_FRACTION:  frac_q <= wr_data[FRAC_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Power store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem_q[mem_raddr];
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && spectrum.valid) begin
			re_q  <= spectrum.data.bin_real;
			im_q  <= spectrum.data.bin_imag;
			img_q <= spectrum.data.image_end;
		end
		if (state_q == S_SQ1) begin
			sq_q <= sq_w;
		end
		if (state_q == S_SQ2) begin
			pw_q <= PW_W'(sq_q) + PW_W'(unsigned'(sq_w));
		end

		// every accumulate step clears the sums ahead of a possible result pass
		if (state_q == S_ACC) begin
			k_q        <= '0;
			den_q      <= '0;
			mom_q      <= '0;
			peak_val_q <= '0;
			peak_idx_q <= '0;
		end
		if (state_q == S_SCAN) begin
			k_q <= k_q + 1'b1;
		end
		kd_s1 <= k_q[IDX_W-1:0];
		if (v_s1) begin
			den_q   <= den_q + DEN_W'(rd_data_q);
			prod_s2 <= $signed({1'b0, rd_data_q}) * diff_w;
			// first strict maximum wins
			if (rd_data_q > peak_val_q) begin
				peak_val_q <= rd_data_q;
				peak_idx_q <= kd_s1;
			end
		end
		if (v_s2) begin
			mom_q <= mom_q + MOM_W'(prod_s2);
		end

		if (state_q == S_THR) begin
			thr_q    <= THR_W'(peak_val_q) * THR_W'(frac_q);
			lo_q     <= peak_idx_q;
			hi_q     <= peak_idx_q;
			cen_q    <= '0;
			status_q <= (den_q == '0) ? STATUS_NO_ENERGY : STATUS_OK;
		end
		if (state_q == S_LO_CMP && above_w) begin
			lo_q <= lo_q - 1'b1;
		end
		if (state_q == S_HI_CMP && above_w) begin
			hi_q <= hi_q + 1'b1;
		end

		if (state_q == S_NUM_WAIT && mul_done) begin
			num_q <= mul_prod[NUM_W-1:0];
		end
		if (state_q == S_CDIV_WAIT && div_done) begin
			cen_q <= cen_w;
		end
		if (state_q == S_BDIV_WAIT && div_done) begin
			bw_q <= div_quot[OUT_W-1:0];
		end

		if (res_load) begin
			res_q.centroid_q8  <= $signed(cen_q);
			res_q.bandwidth_q8 <= bw_q;
			res_q.status       <= status_q;
		end
	end

	dcbe_mul #(
		.A_W (MA_W),
		.B_W (MB_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	dcbe_div #(
		.N_W (DIVN_W),
		.D_W (DIVD_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign spectrum.ready = in_ready;
	assign estimate.valid = res_valid_q;
	assign estimate.data  = res_q;
endmodule

/* tb/doppler_centroid_bandwidth_estimator_tb.sv */
// ----------------------------------------------------------------------------
// doppler_centroid_bandwidth_estimator_tb
// Streams spectrum bins through the estimator under random idling on both
// channels, predicts each centroid/bandwidth word and compares it per field.
// ----------------------------------------------------------------------------
module doppler_centroid_bandwidth_estimator_tb;
	import dcbe_pkg::*;

	localparam int          NBINS    = 1024;
	localparam int          ACC_W    = 48;
	localparam longint unsigned ACC_MAX = (64'd1 << ACC_W) - 64'd1;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	reg_idx_t              wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	dcbe_stream_if #(.word_t(bin_word_t))    spectrum_ch ();
	dcbe_stream_if #(.word_t(result_word_t)) estimate_ch ();

	doppler_centroid_bandwidth_estimator #(
		.MAX_BINS   (NBINS),
		.ACCUM_WIDTH(ACC_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.spectrum(spectrum_ch),
		.estimate(estimate_ch)
	);

	// Shadow of the block: per-bin power, column position and registers
	longint unsigned power_acc [NBINS];
	int unsigned     column_pos;
	bit [SL_W-1:0]   len_reg;
	bit [FS_W-1:0]   rate_reg;
	bit [FRAC_W-1:0] frac_reg;

	bin_word_t    bins_pending [$];
	result_word_t estimates_due [$];

	int  errors;
	int  bins_sent;
	int  estimates_seen;
	int  no_energy_seen;
	bit  bin_taken;
	int  in_gap;
	int  out_gap;
	bit  steady;

	initial begin
		clk = 1'b0;
	end
	always #4 clk = ~clk;

	// Mostly short gaps, a few long ones; none at all in a steady stretch
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	function automatic bit over_threshold(longint unsigned pw, longint unsigned pk);
		bit [127:0] lhs;
		bit [127:0] rhs;
		lhs = 128'(pw) << 16;
		rhs = 128'(pk) * 128'(frac_reg);
		return lhs > rhs;
	endfunction

	// Centroid, bandwidth and status over the first len bins of the store
	function automatic result_word_t compute_estimate(int unsigned len);
		result_word_t    r;
		bit [127:0]      up_mom;
		bit [127:0]      down_mom;
		bit [127:0]      total;
		bit [127:0]      mag;
		bit [127:0]      num;
		bit [127:0]      scaled;
		bit [127:0]      quo;
		longint unsigned fs256;
		longint unsigned m;
		longint unsigned bw;
		int unsigned     centre;
		int unsigned     peak;
		int unsigned     lo;
		int unsigned     hi;
		bit              negative;
		up_mom   = '0;
		down_mom = '0;
		total    = '0;
		peak     = 0;
		centre   = len / 2;
		fs256    = longint'(rate_reg) * 256;
		for (int unsigned k = 0; k < len; k++) begin
			total += 128'(power_acc[k]);
			if (k > centre)
				up_mom += 128'(power_acc[k]) * 128'(k - centre);
			else if (k < centre)
				down_mom += 128'(power_acc[k]) * 128'(centre - k);
			if (power_acc[k] > power_acc[peak])
				peak = k;
		end
		r = '0;
		if (total == 0) begin
			r.status = STATUS_NO_ENERGY;
		end else begin
			r.status = STATUS_OK;
			negative = down_mom > up_mom;
			mag      = negative ? down_mom - up_mom : up_mom - down_mom;
			num      = mag * 128'(fs256);
			scaled   = total * 128'(len);
			quo      = (num + num + scaled) / (scaled + scaled);
			m        = (quo > 128'd16777216) ? 64'd16777216 : quo[63:0];
			if (negative)
				r.centroid_q8 = OUT_W'(-longint'(m));
			else
				r.centroid_q8 = OUT_W'((m > 64'd16777215) ? 64'd16777215 : m);
		end
		// Walk outward from the first peak while power stays over the threshold
		lo = peak;
		hi = peak;
		while (lo > 0 && over_threshold(power_acc[lo], power_acc[peak]))
			lo--;
		while (hi + 1 < len && over_threshold(power_acc[hi], power_acc[peak]))
			hi++;
		bw = (longint'(hi - lo) * fs256 * 2 + len) / (2 * longint'(len));
		r.bandwidth_q8 = OUT_W'(bw);
		return r;
	endfunction

	// Advance the shadow by one accepted bin word
	function automatic void absorb_bin(bin_word_t w);
		int unsigned     len;
		longint signed   re;
		longint signed   im;
		longint unsigned pw;
		longint unsigned s;
		len = len_reg;
		if (len < MIN_BINS)
			len = MIN_BINS;
		if (len > NBINS)
			len = NBINS;
		re = w.bin_real;
		im = w.bin_imag;
		pw = longint'(re * re + im * im);
		if (column_pos < NBINS) begin
			s = power_acc[column_pos];
			power_acc[column_pos] = (pw > ACC_MAX - s) ? ACC_MAX : s + pw;
		end
		if (column_pos + 1 >= len) begin
			column_pos = 0;
			if (w.image_end) begin
				estimates_due.push_back(compute_estimate(len));
				foreach (power_acc[i])
					power_acc[i] = 0;
			end
		end else begin
			column_pos++;
		end
	endfunction

	// Spectrum driver: hold a word until taken, then gap or advance
	always @(negedge clk) begin
		if (!arst_n) begin
			spectrum_ch.valid <= 1'b0;
		end else if (!(spectrum_ch.valid && !bin_taken)) begin
			bin_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				spectrum_ch.valid <= 1'b0;
			end else if (bins_pending.size() > 0) begin
				spectrum_ch.data  <= bins_pending.pop_front();
				spectrum_ch.valid <= 1'b1;
				in_gap = pick_gap();
			end else begin
				spectrum_ch.valid <= 1'b0;
			end
		end
	end

	// Estimate sink: stall ready at random
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			estimate_ch.ready <= 1'b0;
		end else begin
			estimate_ch.ready <= 1'b1;
			out_gap = pick_gap();
		end
	end

	// Capture accepted bins into the shadow model
	always @(posedge clk) begin
		if (arst_n && spectrum_ch.valid && spectrum_ch.ready) begin
			absorb_bin(spectrum_ch.data);
			bin_taken = 1'b1;
			bins_sent++;
		end
	end

	// Check each estimate word against the oldest prediction
	always @(posedge clk) begin
		result_word_t want;
		result_word_t got;
		if (arst_n && estimate_ch.valid && estimate_ch.ready) begin
			got = estimate_ch.data;
			estimates_seen++;
			if (estimates_due.size() == 0) begin
				errors++;
				$display("%0t unexpected estimate: expected none, actual %p", $time, got);
			end else begin
				want = estimates_due.pop_front();
				if (got.status == STATUS_NO_ENERGY)
					no_energy_seen++;
				if (got.centroid_q8 !== want.centroid_q8) begin
					errors++;
					$display("%0t centroid_q8: expected %0d, actual %0d", $time,
						want.centroid_q8, got.centroid_q8);
				end
				if (got.bandwidth_q8 !== want.bandwidth_q8) begin
					errors++;
					$display("%0t bandwidth_q8: expected %0d, actual %0d", $time,
						want.bandwidth_q8, got.bandwidth_q8);
				end
				if (got.status !== want.status) begin
					errors++;
					$display("%0t status: expected %0b, actual %0b", $time,
						want.status, got.status);
				end
			end
		end
	end

	// Hold off until every queued bin is taken and every estimate has come
	task automatic drain();
		while (bins_pending.size() > 0 || spectrum_ch.valid || estimates_due.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Write one register and mirror it in the shadow
	task automatic write_reg(reg_idx_t idx, int unsigned value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_DATA_W'(value);
		case (idx)
			REG_SPECTRUM_LENGTH: len_reg  = SL_W'(value);
			REG_AZIMUTH_RATE:    rate_reg = FS_W'(value);
			default:             frac_reg = FRAC_W'(value);
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic push_bin(int re, int im, bit last_col);
		bin_word_t w;
		w.bin_real  = SAMPLE_W'(re);
		w.bin_imag  = SAMPLE_W'(im);
		w.image_end = last_col;
		bins_pending.push_back(w);
	endtask

	// One image of ncols columns of len bins with a random shape: all zero, noise or a peak
	task automatic push_image(int len, int ncols);
		int peak_at;
		int amp;
		int spread;
		int a;
		int kind;
		peak_at = $urandom_range(len - 1);
		amp     = $urandom_range(32767);
		spread  = $urandom_range(len, 1);
		kind    = $urandom_range(9);
		for (int c = 0; c < ncols; c++) begin
			for (int k = 0; k < len; k++) begin
				if (kind == 0) begin
					a = 0;
				end else if (kind < 3) begin
					a = $urandom_range(65535) - 32768;
				end else begin
					a = amp - (amp / spread) * ((k > peak_at) ? k - peak_at : peak_at - k);
					if (a < 0)
						a = 0;
				end
				// Stray image_end marks in early columns; one on a column's last bin ends the image there
				push_bin(kind == 0 ? 0 : ($urandom_range(1) ? a : -a),
					kind == 0 ? 0 : $urandom_range(65535) - 32768,
					(c == ncols - 1) || ($urandom_range(15) == 0));
			end
		end
	endtask

	initial begin
		int n_len;
		int rate_pick;
		wr_en             = 1'b0;
		wr_index          = REG_SPECTRUM_LENGTH;
		wr_data           = '0;
		spectrum_ch.valid = 1'b0;
		spectrum_ch.data  = '0;
		estimate_ch.ready = 1'b0;
		bin_taken         = 1'b0;
		in_gap            = 0;
		out_gap           = 0;
		steady            = 1'b0;
		errors            = 0;
		bins_sent         = 0;
		estimates_seen    = 0;
		no_energy_seen    = 0;
		column_pos        = 0;
		len_reg           = SL_RESET;
		rate_reg          = FS_RESET;
		frac_reg          = FRAC_RESET;
		foreach (power_acc[i])
			power_acc[i] = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Length below the minimum acts as four bins
		write_reg(REG_SPECTRUM_LENGTH, 0);
		// Full-scale corners on both parts
		push_bin(-32768, -32768, 1'b0);
		push_bin(32767, 32767, 1'b0);
		push_bin(-32768, 32767, 1'b0);
		push_bin(0, 0, 1'b1);
		// No energy column
		for (int k = 0; k < 4; k++)
			push_bin(0, 0, 1'b1);
		// image_end on an early bin only accumulates
		push_bin(100, 0, 1'b1);
		push_bin(0, 0, 1'b0);
		push_bin(0, -5, 1'b0);
		push_bin(7, 7, 1'b1);
		drain();

		// Zero fraction, zero rate, then a length change mid-column
		write_reg(REG_POWER_FRACTION, 0);
		write_reg(REG_AZIMUTH_RATE, 0);
		push_bin(1, 0, 1'b0);
		push_bin(0, 300, 1'b0);
		push_bin(-2, 0, 1'b0);
		push_bin(9, 9, 1'b1);
		drain();
		write_reg(REG_AZIMUTH_RATE, 131071);
		write_reg(REG_POWER_FRACTION, 65535);
		write_reg(REG_SPECTRUM_LENGTH, 8);
		push_bin(500, 0, 1'b0);
		push_bin(-400, 20, 1'b0);
		drain();
		write_reg(REG_SPECTRUM_LENGTH, 2047);
		write_reg(REG_SPECTRUM_LENGTH, 4);
		push_bin(3, -3, 1'b1);
		push_bin(32767, -32768, 1'b1);
		drain();

		// Random images, mostly short columns; a full-length one only early on
		write_reg(REG_AZIMUTH_RATE, 100000);
		write_reg(REG_POWER_FRACTION, 32768);
		while (bins_sent + bins_pending.size() < 1850) begin
			if ($urandom_range(2) == 0) begin
				drain();
				steady = ($urandom_range(3) == 0);
				n_len  = $urandom_range(9);
				if (n_len == 0)
					write_reg(REG_SPECTRUM_LENGTH, $urandom_range(3));
				else if (n_len == 1 && bins_sent + bins_pending.size() < 800)
					write_reg(REG_SPECTRUM_LENGTH, $urandom_range(2047, 1025));
				else if (n_len == 2)
					write_reg(REG_SPECTRUM_LENGTH, $urandom_range(64, 17));
				else
					write_reg(REG_SPECTRUM_LENGTH, $urandom_range(16, 4));
				rate_pick = $urandom_range(5);
				write_reg(REG_AZIMUTH_RATE, rate_pick == 0 ? $urandom_range(1) * 131071 :
					rate_pick == 1 ? 1 : $urandom_range(131071));
				write_reg(REG_POWER_FRACTION, $urandom_range(3) == 0 ?
					$urandom_range(1) * 65535 : $urandom_range(65535));
			end
			n_len = len_reg < MIN_BINS ? MIN_BINS : (len_reg > NBINS ? NBINS : len_reg);
			// Keep the full-length images to a single column
			push_image(n_len, n_len > 64 ? 1 : $urandom_range(3, 1));
			if (n_len > 64) begin
				drain();
				write_reg(REG_SPECTRUM_LENGTH, $urandom_range(16, 4));
			end
			while (bins_pending.size() > 8)
				@(posedge clk);
		end

		drain();
		repeat (100) @(posedge clk);
		if (estimates_due.size() > 0) begin
			errors++;
			$display("%0t missing estimates: expected %0d more, actual 0", $time,
				estimates_due.size());
		end
		$display("Sent %0d spectrum bins; checked %0d estimates, %0d with no energy.",
			bins_sent, estimates_seen, no_energy_seen);
		$display("Covered clamped lengths, extreme rates and fractions, mid-column changes.");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#200000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
hdl/dcbe_pkg.sv
hdl/dcbe_stream_if.sv
hdl/dcbe_mul.sv
hdl/dcbe_div.sv
hdl/doppler_centroid_bandwidth_estimator.sv
tb/doppler_centroid_bandwidth_estimator_tb.sv
